// ----- design/mdid_pkg.sv -----
// Package for the Modbus TCP device identification extractor.
// Holds the parser phase type, the queued item type and the protocol constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mdid_pkg;

  // Configuration port
  localparam int AddrW = 2;
  localparam logic [AddrW-1:0] REG_SERVER_PORT = 2'd0;
  localparam logic [15:0] SERVER_PORT_RESET = 16'd502;

  // Frame offsets of interest, fixed 20-byte IP and TCP headers assumed
  localparam logic [15:0] POS_ETYPE_HI = 16'd12;
  localparam logic [15:0] POS_ETYPE_LO = 16'd13;
  localparam logic [15:0] POS_IP_PROTO = 16'd23;
  localparam logic [15:0] POS_SPORT_HI = 16'd34;
  localparam logic [15:0] POS_SPORT_LO = 16'd35;
  localparam logic [15:0] POS_MBLEN_HI = 16'd58;
  localparam logic [15:0] POS_MBLEN_LO = 16'd59;
  localparam logic [15:0] POS_FUNC = 16'd61;
  localparam logic [15:0] MB_PAYLOAD_START = 16'd62;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0] IP_PROTO_TCP = 8'd6;
  localparam logic [7:0] FUNC_DEVICE_ID = 8'd43;
  localparam logic [7:0] FUNC_SERVER_ID = 8'd17;
  localparam logic [7:0] MEI_DEVICE_ID = 8'd14;
  localparam logic [7:0] CONFORMITY_EXT = 8'd3;
  localparam logic [7:0] LAST_STD_OBJECT = 8'h05;

  // Payload offsets within the device identification response header
  localparam logic [15:0] OFF_MEI = 16'd0;
  localparam logic [15:0] OFF_CONFORMITY = 16'd2;
  localparam logic [15:0] OFF_OBJ_COUNT = 16'd5;
  localparam logic [15:0] DEVID_HDR_LEN = 16'd6;

  localparam logic [2:0] KIND_SERVER_ID = 3'd6;
  localparam logic [2:0] KIND_NONE = 3'd7;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HDR,
    PH_F43,
    PH_OBJ_ID,
    PH_OBJ_LEN,
    PH_OBJ_DATA,
    PH_F17,
    PH_SKIP
  } phase_t;

  typedef struct packed {
    logic        is_clear;
    logic [7:0]  frame_byte;
    logic        frame_last;
    logic [15:0] capture_length;
  } item_t;

endpackage

`default_nettype wire

// ----- design/mdid_front.sv -----
// Front end of the extractor: accepts items, classifies them and queues them.
// Two-entry queue toward the parser. Depends on mdid_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mdid_front import mdid_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_ready,
  input  wire logic        op,
  input  wire logic [7:0]  frame_byte,
  input  wire logic        frame_last,
  input  wire logic [15:0] capture_length,
  output logic             head_valid,
  output item_t            head,
  input  wire logic        head_pop
);

  item_t      entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  assign item_ready = (count != 2'd2);
  assign push = item_valid && item_ready;
  assign head_valid = (count != 2'd0);
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= '{is_clear: op, frame_byte: frame_byte,
                           frame_last: frame_last, capture_length: capture_length};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (head_pop) rd_ptr <= ~rd_ptr;
      case ({push, head_pop})
        2'b10: count <= count + 2'd1;
        2'b01: count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- design/mdid_parse.sv -----
// Back end of the extractor: walks the frame bytes, tracks the found flags and
// drives the result register. Depends on mdid_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mdid_parse import mdid_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [15:0] server_port,
  input  wire logic        head_valid,
  input  item_t            head,
  output logic             head_pop,
  output logic             info_valid,
  input  wire logic        info_ready,
  output logic [2:0]       info_kind,
  output logic [7:0]       info_byte,
  output logic             first_of_item,
  output logic             last_of_item,
  output logic             core_complete
);

  phase_t      phase, phase_next;
  logic [15:0] byte_position, byte_position_next;
  logic [15:0] captured_length, captured_length_next;
  logic [15:0] modbus_length, modbus_length_next;
  logic [15:0] payload_left, payload_left_next;
  logic [7:0]  high_byte_hold, high_byte_hold_next;
  logic [2:0]  object_kind, object_kind_next;
  logic [7:0]  object_bytes_left, object_bytes_left_next;
  logic        emit_current, emit_current_next;
  logic [6:0]  found_flags, found_flags_next;
  logic [7:0]  first_len, first_len_next;

  logic        go, clr;
  logic [7:0]  b;
  phase_t      ph_eff;
  logic [15:0] cl_eff, pos_eff, off, hdr_word, pl_dec, pl_after43, avail, cnt;
  logic [7:0]  obl_dec;
  logic [7:0]  flags_ext;
  logic        in_cap, len_bad, obj_fits, kind_known, emit_new, hdr_reject, srv_skip;
  logic        produce;

  // A queued item moves into the parser whenever the result register can take its result.
  assign head_pop = head_valid && (!info_valid || info_ready);
  assign clr = head.is_clear;
  assign go = head_pop && !clr;
  assign b = head.frame_byte;

  // The first byte of a frame samples the capture length and starts at position zero.
  assign ph_eff = (phase != PH_IDLE) ? phase :
                  ((head.capture_length >= MB_PAYLOAD_START) ? PH_HDR : PH_SKIP);
  assign cl_eff = (phase == PH_IDLE) ? head.capture_length : captured_length;
  assign pos_eff = (phase == PH_IDLE) ? 16'd0 : byte_position;
  assign in_cap = pos_eff < cl_eff;
  assign off = pos_eff - MB_PAYLOAD_START;
  assign hdr_word = {high_byte_hold, b};
  assign len_bad = (hdr_word < 16'd2) || ((hdr_word - 16'd2) > (cl_eff - MB_PAYLOAD_START));
  assign hdr_reject = ((pos_eff == POS_ETYPE_LO) && (hdr_word != ETHERTYPE_IPV4)) ||
                      ((pos_eff == POS_IP_PROTO) && (b != IP_PROTO_TCP)) ||
                      ((pos_eff == POS_SPORT_LO) && (hdr_word != server_port)) ||
                      ((pos_eff == POS_MBLEN_LO) && len_bad);
  assign pl_dec = payload_left - 16'd1;
  assign pl_after43 = modbus_length - DEVID_HDR_LEN;
  assign obj_fits = !(pl_dec < {8'd0, b});
  assign obl_dec = object_bytes_left - 8'd1;
  assign flags_ext = {1'b0, found_flags};
  assign kind_known = ({5'd0, object_kind} <= LAST_STD_OBJECT);
  assign emit_new = kind_known && (b != 8'd0) && !flags_ext[object_kind];
  assign avail = modbus_length - 16'd1;
  assign cnt = (avail < {8'd0, b}) ? avail : {8'd0, b};
  assign srv_skip = found_flags[KIND_SERVER_ID] || (cnt == 16'd0);
  assign produce = go && in_cap && (ph_eff == PH_OBJ_DATA) && emit_current;

  // Next parse phase
  always_comb begin
    phase_next = phase;
    if (go) begin
      phase_next = ph_eff;
      if (in_cap) begin
        unique case (ph_eff)
          PH_HDR: begin
            if (hdr_reject) begin
              phase_next = PH_SKIP;
            end else if (pos_eff == POS_FUNC) begin
              if (b == FUNC_DEVICE_ID && modbus_length >= DEVID_HDR_LEN) phase_next = PH_F43;
              else if (b == FUNC_SERVER_ID && modbus_length >= 16'd1) phase_next = PH_F17;
              else phase_next = PH_SKIP;
            end
          end
          PH_F43: begin
            if ((off == OFF_MEI && b != MEI_DEVICE_ID) ||
                (off == OFF_CONFORMITY && b == CONFORMITY_EXT)) begin
              phase_next = PH_SKIP;
            end else if (off == OFF_OBJ_COUNT) begin
              phase_next = (pl_after43 >= 16'd2) ? PH_OBJ_ID : PH_SKIP;
            end
          end
          PH_OBJ_ID: phase_next = PH_OBJ_LEN;
          PH_OBJ_LEN: begin
            if (!obj_fits) phase_next = PH_SKIP;
            else if (b == 8'd0) phase_next = (pl_dec >= 16'd2) ? PH_OBJ_ID : PH_SKIP;
            else phase_next = PH_OBJ_DATA;
          end
          PH_OBJ_DATA: begin
            if (obl_dec == 8'd0) phase_next = (pl_dec >= 16'd2) ? PH_OBJ_ID : PH_SKIP;
          end
          PH_F17: phase_next = srv_skip ? PH_SKIP : PH_OBJ_DATA;
          default: phase_next = ph_eff;
        endcase
      end
      if (head.frame_last) phase_next = PH_IDLE;
    end
  end

  // Datapath and flag updates
  always_comb begin
    byte_position_next = byte_position;
    captured_length_next = captured_length;
    modbus_length_next = modbus_length;
    payload_left_next = payload_left;
    high_byte_hold_next = high_byte_hold;
    object_kind_next = object_kind;
    object_bytes_left_next = object_bytes_left;
    emit_current_next = emit_current;
    found_flags_next = found_flags;
    first_len_next = first_len;
    if (head_pop && clr) begin
      found_flags_next = '0;
    end else if (go) begin
      captured_length_next = cl_eff;
      if (in_cap) begin
        unique case (ph_eff)
          PH_HDR: begin
            if (pos_eff == POS_ETYPE_HI || pos_eff == POS_SPORT_HI ||
                pos_eff == POS_MBLEN_HI) begin
              high_byte_hold_next = b;
            end else if (pos_eff == POS_MBLEN_LO && !len_bad) begin
              modbus_length_next = hdr_word - 16'd2;
            end
          end
          PH_F43: begin
            if (off == OFF_OBJ_COUNT && !(off == OFF_MEI)) payload_left_next = pl_after43;
          end
          PH_OBJ_ID: begin
            object_kind_next = (b <= LAST_STD_OBJECT) ? b[2:0] : KIND_NONE;
            payload_left_next = pl_dec;
          end
          PH_OBJ_LEN: begin
            payload_left_next = pl_dec;
            if (obj_fits) begin
              object_bytes_left_next = b;
              first_len_next = b;
              emit_current_next = emit_new;
              if (emit_new) found_flags_next = found_flags | (7'd1 << object_kind);
            end
          end
          PH_OBJ_DATA: begin
            object_bytes_left_next = obl_dec;
            payload_left_next = pl_dec;
            if (obl_dec == 8'd0) emit_current_next = 1'b0;
          end
          PH_F17: begin
            if (!srv_skip) begin
              found_flags_next = found_flags | (7'd1 << KIND_SERVER_ID);
              object_kind_next = KIND_SERVER_ID;
              object_bytes_left_next = cnt[7:0];
              first_len_next = cnt[7:0];
              payload_left_next = cnt;
              emit_current_next = 1'b1;
            end
          end
          default: ;
        endcase
      end
      byte_position_next = (pos_eff != 16'hFFFF) ? pos_eff + 16'd1 : pos_eff;
      if (head.frame_last) begin
        byte_position_next = '0;
        emit_current_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      byte_position <= '0;
      captured_length <= '0;
      modbus_length <= '0;
      payload_left <= '0;
      high_byte_hold <= '0;
      object_kind <= '0;
      object_bytes_left <= '0;
      emit_current <= 1'b0;
      found_flags <= '0;
      first_len <= '0;
    end else begin
      phase <= phase_next;
      byte_position <= byte_position_next;
      captured_length <= captured_length_next;
      modbus_length <= modbus_length_next;
      payload_left <= payload_left_next;
      high_byte_hold <= high_byte_hold_next;
      object_kind <= object_kind_next;
      object_bytes_left <= object_bytes_left_next;
      emit_current <= emit_current_next;
      found_flags <= found_flags_next;
      first_len <= first_len_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      info_valid <= 1'b0;
    end else if (head_pop) begin
      info_valid <= produce;
    end else if (info_ready) begin
      info_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      info_kind <= object_kind;
      info_byte <= b;
      first_of_item <= (object_bytes_left == first_len);
      last_of_item <= (object_bytes_left == 8'd1);
      core_complete <= &found_flags[2:0];
    end
  end

endmodule

`default_nettype wire

// ----- design/modbus_device_id_extractor.sv -----
// A taken frame byte is written into a queue entry and its result then into the output
// register; bytes and results move at one per cycle while the output is not stalled.
// A two-entry queue decouples input from the parser; a stalled output holds the parser.
// Reset clears the parser to wait for a frame start, clears all found flags and the
// queue, and sets the server port register to 502.
// Top level: APB register port, front queue and parser. Depends on mdid_pkg.
`timescale 1ns / 1ps
`default_nettype none

module modbus_device_id_extractor import mdid_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [31:0]      pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire logic             op,
  input  wire logic [7:0]       frame_byte,
  input  wire logic             frame_last,
  input  wire logic [15:0]      capture_length,
  output logic                  info_valid,
  input  wire logic             info_ready,
  output logic [2:0]            info_kind,
  output logic [7:0]            info_byte,
  output logic                  first_of_item,
  output logic                  last_of_item,
  output logic                  core_complete
);

  logic [15:0] server_port;
  logic        head_valid;
  item_t       head;
  logic        head_pop;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_SERVER_PORT) ? {16'd0, server_port} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      server_port <= SERVER_PORT_RESET;
    end else if (psel && penable && pwrite && pready && paddr == REG_SERVER_PORT) begin
      server_port <= pwdata[15:0];
    end
  end

  mdid_front u_front (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .op             (op),
    .frame_byte     (frame_byte),
    .frame_last     (frame_last),
    .capture_length (capture_length),
    .head_valid     (head_valid),
    .head           (head),
    .head_pop       (head_pop)
  );

  mdid_parse u_parse (
    .clk           (clk),
    .rst           (rst),
    .server_port   (server_port),
    .head_valid    (head_valid),
    .head          (head),
    .head_pop      (head_pop),
    .info_valid    (info_valid),
    .info_ready    (info_ready),
    .info_kind     (info_kind),
    .info_byte     (info_byte),
    .first_of_item (first_of_item),
    .last_of_item  (last_of_item),
    .core_complete (core_complete)
  );

endmodule

`default_nettype wire

// ----- design/mdid_checker.sv -----
// Port-level checks for the extractor, bound to the top level.
// Depends on mdid_pkg and modbus_device_id_extractor.
`timescale 1ns / 1ps
`default_nettype none

module mdid_checker import mdid_pkg::*; (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       pready,
  input wire logic       item_valid,
  input wire logic       item_ready,
  input wire logic       info_valid,
  input wire logic       info_ready,
  input wire logic [2:0] info_kind,
  input wire logic [7:0] info_byte
);

  // Nothing is offered for transfer right after reset.
  assert property (@(posedge clk) rst |=> !info_valid)
    else $error("result offered after reset");

  // A stalled result holds its byte.
  assert property (@(posedge clk) disable iff (rst)
    info_valid && !info_ready |=> info_valid && $stable(info_byte))
    else $error("stalled result changed");

  // Only defined kinds are reported.
  assert property (@(posedge clk) disable iff (rst) info_valid |-> info_kind != KIND_NONE)
    else $error("undefined info kind");

  // The register port never waits.
  assert property (@(posedge clk) disable iff (rst) pready)
    else $error("register port stalled");

  // The queue takes a byte in the cycle after reset.
  assert property (@(posedge clk) $fell(rst) |-> item_ready)
    else $error("input not ready after reset");

endmodule

bind modbus_device_id_extractor mdid_checker u_mdid_checker (
  .clk        (clk),
  .rst        (rst),
  .pready     (pready),
  .item_valid (item_valid),
  .item_ready (item_ready),
  .info_valid (info_valid),
  .info_ready (info_ready),
  .info_kind  (info_kind),
  .info_byte  (info_byte)
);

`default_nettype wire

// ----- bench/tb_modbus_device_id_extractor.sv -----
// Self-checking bench for the Modbus TCP device identification extractor.
// Builds Ethernet frames, follows the parser byte by byte and checks each info transfer.
// Depends on mdid_pkg and modbus_device_id_extractor.
`timescale 1ns / 1ps

module tb_modbus_device_id_extractor;
  import mdid_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 12;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic       is_first;
    logic       is_last;
    logic       core;
  } info_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;
  logic             item_valid = 1'b0;
  logic             item_ready;
  logic             op = 1'b0;
  logic [7:0]       frame_byte = '0;
  logic             frame_last = 1'b0;
  logic [15:0]      capture_length = '0;
  logic             info_valid;
  logic             info_ready = 1'b0;
  logic [2:0]       info_kind;
  logic [7:0]       info_byte;
  logic             first_of_item;
  logic             last_of_item;
  logic             core_complete;

  modbus_device_id_extractor uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .item_valid(item_valid), .item_ready(item_ready), .op(op), .frame_byte(frame_byte),
    .frame_last(frame_last), .capture_length(capture_length),
    .info_valid(info_valid), .info_ready(info_ready), .info_kind(info_kind),
    .info_byte(info_byte), .first_of_item(first_of_item), .last_of_item(last_of_item),
    .core_complete(core_complete)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Parser state as the bench follows it
  logic [15:0] pr_port = SERVER_PORT_RESET;
  phase_t      pr_phase = PH_IDLE;
  logic [15:0] pr_pos = '0;
  logic [15:0] pr_cap = '0;
  logic [15:0] pr_mb_len = '0;
  logic [15:0] pr_left = '0;
  logic [7:0]  pr_hold = '0;
  logic [2:0]  pr_kind = '0;
  logic [7:0]  pr_obj_left = '0;
  logic [7:0]  pr_first_len = '0;
  logic        pr_emit = 1'b0;
  logic [6:0]  pr_found = '0;

  info_t       due_bytes[$];
  logic [7:0]  frame_q[$];
  logic [7:0]  pay_q[$];

  int send_idle = 0;
  int recv_idle = 0;
  int errors = 0;
  int items_sent = 0;
  int frames_sent = 0;
  int results_seen = 0;
  int cycle_count = 0;
  info_t got_info;
  info_t want_info;

  function automatic logic [7:0] rnd8();
    return $urandom;
  endfunction

  function automatic logic [15:0] rnd16();
    return $urandom;
  endfunction

  task automatic flag_error(input string what);
    errors++;
    if (errors <= 10) $display("ERROR: %s", what);
  endtask

  task automatic walk_next();
    pr_phase = (pr_left >= 2) ? PH_OBJ_ID : PH_SKIP;
  endtask

  // Advances the parser copy by one accepted transfer and queues any info byte it yields.
  task automatic parse_item(input bit is_clear, input logic [7:0] b, input bit last,
                            input logic [15:0] cap);
    info_t r;
    bit hit;
    int unsigned p, len, avail, cnt;
    hit = 1'b0;
    items_sent++;
    if (is_clear) begin
      pr_found = '0;
    end else begin
      if (pr_phase == PH_IDLE) begin
        pr_cap = cap;
        pr_pos = '0;
        pr_phase = (cap >= MB_PAYLOAD_START) ? PH_HDR : PH_SKIP;
      end
      if (pr_pos < pr_cap) begin
        p = pr_pos;
        case (pr_phase)
          PH_HDR: begin
            if (p == POS_ETYPE_HI || p == POS_SPORT_HI || p == POS_MBLEN_HI) begin
              pr_hold = b;
            end else if (p == POS_ETYPE_LO) begin
              if ({pr_hold, b} != ETHERTYPE_IPV4) pr_phase = PH_SKIP;
            end else if (p == POS_IP_PROTO) begin
              if (b != IP_PROTO_TCP) pr_phase = PH_SKIP;
            end else if (p == POS_SPORT_LO) begin
              if ({pr_hold, b} != pr_port) pr_phase = PH_SKIP;
            end else if (p == POS_MBLEN_LO) begin
              len = {pr_hold, b};
              if (len < 2 || len - 2 > int'(pr_cap) - int'(MB_PAYLOAD_START)) begin
                pr_phase = PH_SKIP;
              end else begin
                pr_mb_len = len - 2;
              end
            end else if (p == POS_FUNC) begin
              if (b == FUNC_DEVICE_ID && pr_mb_len >= DEVID_HDR_LEN) pr_phase = PH_F43;
              else if (b == FUNC_SERVER_ID && pr_mb_len >= 1) pr_phase = PH_F17;
              else pr_phase = PH_SKIP;
            end
          end
          PH_F43: begin
            if (p - MB_PAYLOAD_START == OFF_MEI && b != MEI_DEVICE_ID) begin
              pr_phase = PH_SKIP;
            end else if (p - MB_PAYLOAD_START == OFF_CONFORMITY && b == CONFORMITY_EXT) begin
              pr_phase = PH_SKIP;
            end else if (p - MB_PAYLOAD_START == OFF_OBJ_COUNT) begin
              pr_left = pr_mb_len - DEVID_HDR_LEN;
              walk_next();
            end
          end
          PH_OBJ_ID: begin
            pr_kind = (b <= LAST_STD_OBJECT) ? b[2:0] : KIND_NONE;
            pr_left = pr_left - 1;
            pr_phase = PH_OBJ_LEN;
          end
          PH_OBJ_LEN: begin
            pr_left = pr_left - 1;
            if (pr_left < b) begin
              pr_phase = PH_SKIP;
            end else begin
              pr_obj_left = b;
              pr_first_len = b;
              pr_emit = 1'b0;
              if (pr_kind <= LAST_STD_OBJECT && b != 0) begin
                if (!pr_found[pr_kind]) pr_emit = 1'b1;
              end
              if (pr_emit) pr_found[pr_kind] = 1'b1;
              if (b == 0) walk_next();
              else pr_phase = PH_OBJ_DATA;
            end
          end
          PH_OBJ_DATA: begin
            if (pr_emit) begin
              r.kind = pr_kind;
              r.data = b;
              r.is_first = (pr_obj_left == pr_first_len);
              r.is_last = (pr_obj_left == 1);
              hit = 1'b1;
            end
            pr_obj_left = pr_obj_left - 1;
            pr_left = pr_left - 1;
            if (pr_obj_left == 0) begin
              pr_emit = 1'b0;
              walk_next();
            end
          end
          PH_F17: begin
            avail = pr_mb_len - 1;
            cnt = (avail < b) ? avail : b;
            if (pr_found[KIND_SERVER_ID] || cnt == 0) begin
              pr_phase = PH_SKIP;
            end else begin
              pr_found[KIND_SERVER_ID] = 1'b1;
              pr_kind = KIND_SERVER_ID;
              pr_obj_left = cnt;
              pr_first_len = cnt;
              pr_left = cnt;
              pr_emit = 1'b1;
              pr_phase = PH_OBJ_DATA;
            end
          end
          default: ;
        endcase
      end
      if (pr_pos != 16'hFFFF) pr_pos = pr_pos + 1;
      if (last) begin
        pr_phase = PH_IDLE;
        pr_pos = '0;
        pr_emit = 1'b0;
      end
      if (hit) begin
        r.core = &pr_found[2:0];
        due_bytes.push_back(r);
      end
    end
  endtask

  // One input transfer; valid stays high on return so back-to-back items need no gap.
  task automatic send_item(input bit is_clear, input logic [7:0] b, input bit last,
                           input logic [15:0] cap);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      item_valid = 1'b0;
      @(negedge clk);
    end
    item_valid = 1'b1;
    op = is_clear;
    frame_byte = b;
    frame_last = last;
    capture_length = cap;
    @(posedge clk);
    while (item_ready !== 1'b1) @(posedge clk);
    parse_item(is_clear, b, last, cap);
  endtask

  task automatic send_clear();
    send_item(1'b1, rnd8(), $urandom_range(1), rnd16());
  endtask

  task automatic send_frame(input int cap, input int clr_pct, input int clear_at);
    for (int i = 0; i < frame_q.size(); i++) begin
      if (i == clear_at || $urandom_range(99) < clr_pct) send_clear();
      send_item(1'b0, frame_q[i], i == frame_q.size() - 1, (i == 0) ? cap : rnd16());
    end
    frames_sent++;
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    item_valid = 1'b0;
    while (due_bytes.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic apb_access(input bit wr, input logic [15:0] val, output logic [31:0] rd);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = wr;
    paddr = REG_SERVER_PORT;
    pwdata = {16'h0, val};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    rd = prdata;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic set_server_port(input logic [15:0] v);
    logic [31:0] rd;
    wait_results_drained();
    apb_access(1'b1, v, rd);
    pr_port = v;
    apb_access(1'b0, 16'h0, rd);
    if (rd !== {16'h0, v})
      flag_error($sformatf("server port read back %08h, expected %08h", rd, {16'h0, v}));
  endtask

  // Frame builders work on pay_q (Modbus data after the function code) and frame_q.
  task automatic hdr_frame(input logic [15:0] port, input logic [7:0] func,
                           input logic [15:0] lenf, input logic [15:0] etype,
                           input logic [7:0] proto);
    logic [7:0] v;
    frame_q.delete();
    for (int i = 0; i < MB_PAYLOAD_START; i++) begin
      v = rnd8();
      if (i == POS_ETYPE_HI) v = etype[15:8];
      else if (i == POS_ETYPE_LO) v = etype[7:0];
      else if (i == POS_IP_PROTO) v = proto;
      else if (i == POS_SPORT_HI) v = port[15:8];
      else if (i == POS_SPORT_LO) v = port[7:0];
      else if (i == POS_MBLEN_HI) v = lenf[15:8];
      else if (i == POS_MBLEN_LO) v = lenf[7:0];
      else if (i == POS_FUNC) v = func;
      frame_q.push_back(v);
    end
    foreach (pay_q[i]) frame_q.push_back(pay_q[i]);
  endtask

  task automatic mb_frame(input logic [7:0] func);
    hdr_frame(pr_port, func, pay_q.size() + 2, ETHERTYPE_IPV4, IP_PROTO_TCP);
  endtask

  task automatic devid_head(input logic [7:0] mei, input logic [7:0] conformity);
    pay_q.delete();
    pay_q.push_back(mei);
    pay_q.push_back(8'd1);
    pay_q.push_back(conformity);
    pay_q.push_back(8'h00);
    pay_q.push_back(8'h00);
    pay_q.push_back(8'd3);
  endtask

  task automatic add_obj(input logic [7:0] id, input logic [7:0] len);
    pay_q.push_back(id);
    pay_q.push_back(len);
    repeat (len) pay_q.push_back(rnd8());
  endtask

  task automatic server_id_payload(input logic [7:0] count, input int n);
    pay_q.delete();
    pay_q.push_back(count);
    repeat (n) pay_q.push_back(rnd8());
  endtask

  task automatic test_device_id_walk();
    send_clear();
    devid_head(MEI_DEVICE_ID, 8'd1);
    add_obj(8'd0, 8'd4);
    add_obj(8'd3, 8'd0);
    add_obj(8'd1, 8'd3);
    add_obj(8'h80, 8'd3);
    add_obj(8'd2, 8'd1);
    add_obj(8'd0, 8'd2);
    add_obj(8'd6, 8'd2);
    add_obj(8'hFF, 8'd1);
    add_obj(LAST_STD_OBJECT, 8'd5);
    add_obj(8'd4, 8'd255);
    // The trailing object claims more bytes than the Modbus length leaves.
    pay_q.push_back(8'd3);
    pay_q.push_back(8'd9);
    pay_q.push_back(rnd8());
    mb_frame(FUNC_DEVICE_ID);
    send_frame(frame_q.size(), 0, -1);
    // A single byte left after an object ends the walk.
    devid_head(MEI_DEVICE_ID, 8'd2);
    add_obj(8'd3, 8'd2);
    pay_q.push_back(8'd3);
    mb_frame(FUNC_DEVICE_ID);
    send_frame(frame_q.size(), 0, -1);
  endtask

  task automatic test_server_id();
    send_clear();
    server_id_payload(8'd4, 5);
    mb_frame(FUNC_SERVER_ID);
    send_frame(frame_q.size(), 0, -1);
    server_id_payload(8'd2, 3);
    mb_frame(FUNC_SERVER_ID);
    send_frame(frame_q.size(), 0, -1);
    send_clear();
    server_id_payload(8'd0, 2);
    mb_frame(FUNC_SERVER_ID);
    send_frame(frame_q.size(), 0, -1);
    // A byte count beyond the Modbus length is cut to what is there.
    server_id_payload(8'd255, 3);
    mb_frame(FUNC_SERVER_ID);
    send_frame(frame_q.size(), 0, -1);
    send_clear();
    server_id_payload(8'd5, 0);
    mb_frame(FUNC_SERVER_ID);
    send_frame(frame_q.size(), 0, -1);
    pay_q.delete();
    mb_frame(FUNC_SERVER_ID);
    send_frame(frame_q.size(), 0, -1);
  endtask

  task automatic test_header_rejects();
    send_clear();
    devid_head(MEI_DEVICE_ID, 8'd1);
    add_obj(8'd0, 8'd3);
    mb_frame(FUNC_DEVICE_ID);
    send_frame(MB_PAYLOAD_START - 1, 0, -1);
    send_frame(0, 0, -1);
    hdr_frame(pr_port, FUNC_DEVICE_ID, pay_q.size() + 2, 16'h86DD, IP_PROTO_TCP);
    send_frame(frame_q.size(), 0, -1);
    hdr_frame(pr_port, FUNC_DEVICE_ID, pay_q.size() + 2, ETHERTYPE_IPV4, 8'd17);
    send_frame(frame_q.size(), 0, -1);
    hdr_frame(pr_port ^ 16'h1, FUNC_DEVICE_ID, pay_q.size() + 2, ETHERTYPE_IPV4, IP_PROTO_TCP);
    send_frame(frame_q.size(), 0, -1);
    hdr_frame(pr_port, FUNC_DEVICE_ID, 16'd1, ETHERTYPE_IPV4, IP_PROTO_TCP);
    send_frame(frame_q.size(), 0, -1);
    hdr_frame(pr_port, FUNC_DEVICE_ID, 16'd0, ETHERTYPE_IPV4, IP_PROTO_TCP);
    send_frame(frame_q.size(), 0, -1);
    hdr_frame(pr_port, FUNC_DEVICE_ID, pay_q.size() + 3, ETHERTYPE_IPV4, IP_PROTO_TCP);
    send_frame(frame_q.size(), 0, -1);
    mb_frame(8'd3);
    send_frame(frame_q.size(), 0, -1);
    // Device identification response one byte short of its header.
    devid_head(MEI_DEVICE_ID, 8'd1);
    void'(pay_q.pop_back());
    mb_frame(FUNC_DEVICE_ID);
    send_frame(frame_q.size(), 0, -1);
    devid_head(8'd13, 8'd1);
    add_obj(8'd0, 8'd3);
    mb_frame(FUNC_DEVICE_ID);
    send_frame(frame_q.size(), 0, -1);
    devid_head(MEI_DEVICE_ID, CONFORMITY_EXT);
    add_obj(8'd0, 8'd3);
    mb_frame(FUNC_DEVICE_ID);
    send_frame(frame_q.size(), 0, -1);
    // Single-byte frame.
    frame_q.delete();
    frame_q.push_back(rnd8());
    send_frame(16'hFFFF, 0, -1);
  endtask

  task automatic test_cut_short();
    int lenf;
    send_clear();
    devid_head(MEI_DEVICE_ID, 8'd1);
    add_obj(8'd0, 8'd8);
    lenf = pay_q.size() + 2;
    repeat (5) void'(pay_q.pop_back());
    hdr_frame(pr_port, FUNC_DEVICE_ID, lenf, ETHERTYPE_IPV4, IP_PROTO_TCP);
    send_frame(1000, 0, -1);
    // Kind 0 stays found after the cut string.
    devid_head(MEI_DEVICE_ID, 8'd1);
    add_obj(8'd0, 8'd3);
    add_obj(8'd1, 8'd2);
    mb_frame(FUNC_DEVICE_ID);
    send_frame(frame_q.size(), 0, -1);
    // Trailing bytes past the capture hold an object that must not come out.
    devid_head(MEI_DEVICE_ID, 8'd1);
    add_obj(8'd2, 8'd6);
    mb_frame(FUNC_DEVICE_ID);
    repeat (2) begin
      frame_q.push_back(8'd4);
      frame_q.push_back(8'd1);
      frame_q.push_back(rnd8());
    end
    send_frame(frame_q.size() - 6, 0, -1);
    // Flags cleared in the middle of a string; the string runs on.
    devid_head(MEI_DEVICE_ID, 8'd1);
    add_obj(LAST_STD_OBJECT, 8'd6);
    add_obj(8'd0, 8'd2);
    mb_frame(FUNC_DEVICE_ID);
    send_frame(frame_q.size(), 0, MB_PAYLOAD_START + 10);
  endtask

  task automatic test_port_extremes();
    set_server_port(16'h0000);
    send_clear();
    devid_head(MEI_DEVICE_ID, 8'd1);
    add_obj(8'd1, 8'd2);
    mb_frame(FUNC_DEVICE_ID);
    send_frame(frame_q.size(), 0, -1);
    server_id_payload(8'd1, 2);
    mb_frame(FUNC_SERVER_ID);
    send_frame(frame_q.size(), 0, -1);
    set_server_port(16'hFFFF);
    send_clear();
    devid_head(MEI_DEVICE_ID, 8'd1);
    add_obj(8'd2, 8'd3);
    mb_frame(FUNC_DEVICE_ID);
    send_frame(frame_q.size(), 0, -1);
    hdr_frame(SERVER_PORT_RESET, FUNC_DEVICE_ID, pay_q.size() + 2, ETHERTYPE_IPV4,
              IP_PROTO_TCP);
    send_frame(frame_q.size(), 0, -1);
  endtask

  // A frame past 65535 bytes drives the position counter into saturation.
  task automatic test_position_saturation();
    send_idle = 0;
    recv_idle = 0;
    send_clear();
    devid_head(MEI_DEVICE_ID, 8'd1);
    while (pay_q.size() < 16'hFFFF - MB_PAYLOAD_START)
      add_obj($urandom_range(9), $urandom_range(255));
    hdr_frame(pr_port, FUNC_DEVICE_ID, 16'hFFFF - MB_PAYLOAD_START + 2, ETHERTYPE_IPV4,
              IP_PROTO_TCP);
    while (frame_q.size() < 65540) frame_q.push_back(rnd8());
    send_frame(16'hFFFF, 0, -1);
  endtask

  task automatic make_random_frame(output int cap);
    int r, n, pick, size;
    logic [15:0] fport, lenf, etype;
    logic [7:0] func, proto, len;
    fport = ($urandom_range(9) == 0) ? rnd16() : pr_port;
    etype = ETHERTYPE_IPV4;
    proto = IP_PROTO_TCP;
    r = $urandom_range(99);
    if (r < 60) begin
      devid_head(($urandom_range(19) == 0) ? rnd8() : MEI_DEVICE_ID,
                 ($urandom_range(9) == 0) ? CONFORMITY_EXT : rnd8());
      n = $urandom_range(1, 8);
      repeat (n) begin
        pick = $urandom_range(9);
        len = (pick < 7) ? $urandom_range(6) : (pick < 9) ? $urandom_range(30) : rnd8();
        add_obj(($urandom_range(4) == 0) ? rnd8() : $urandom_range(5), len);
      end
      if ($urandom_range(9) == 0) begin
        pay_q.push_back($urandom_range(5));
        if ($urandom_range(1)) begin
          len = $urandom_range(1, 20);
          pay_q.push_back(len);
          repeat ($urandom_range(len - 1)) pay_q.push_back(rnd8());
        end
      end
      func = FUNC_DEVICE_ID;
    end else if (r < 85) begin
      server_id_payload(($urandom_range(4) == 0) ? rnd8() : $urandom_range(10),
                        $urandom_range(12));
      func = FUNC_SERVER_ID;
    end else begin
      pay_q.delete();
      repeat ($urandom_range(10)) pay_q.push_back(rnd8());
      func = rnd8();
    end
    lenf = pay_q.size() + 2;
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(3))
        0: etype = rnd16();
        1: proto = rnd8();
        2: lenf = rnd16();
        default: lenf = $urandom_range(1);
      endcase
    end
    hdr_frame(fport, func, lenf, etype, proto);
    if ($urandom_range(19) == 0) begin
      frame_q.delete();
      repeat ($urandom_range(1, 80)) frame_q.push_back(rnd8());
    end
    size = frame_q.size();
    pick = $urandom_range(19);
    if (pick == 0) cap = $urandom_range(65535);
    else if (pick == 1) cap = size + $urandom_range(300);
    else if (pick == 2) cap = size - $urandom_range((size < 30) ? size : 30);
    else cap = size;
  endtask

  task automatic run_random_traffic(input int sp, input int rp, input logic [15:0] port,
                                    input int target);
    int start, cap;
    send_idle = sp;
    recv_idle = rp;
    set_server_port(port);
    start = items_sent;
    while (items_sent - start < target) begin
      if ($urandom_range(19) == 0) wait_results_drained();
      if ($urandom_range(9) < 7) send_clear();
      make_random_frame(cap);
      send_frame(cap, ($urandom_range(6) == 0) ? 3 : 0, -1);
    end
  endtask

  always @(negedge clk) info_ready <= ($urandom_range(99) >= recv_idle);

  always @(posedge clk) begin
    if (!rst && info_valid && info_ready) begin
      got_info = '{info_kind, info_byte, first_of_item, last_of_item, core_complete};
      results_seen++;
      if (due_bytes.size() == 0) begin
        flag_error($sformatf("unexpected info transfer kind %0d byte %02h first %0b last %0b core %0b",
                             got_info.kind, got_info.data, got_info.is_first,
                             got_info.is_last, got_info.core));
      end else begin
        want_info = due_bytes.pop_front();
        if (got_info !== want_info)
          flag_error($sformatf("info byte %0d: expected kind %0d byte %02h first %0b last %0b core %0b, got kind %0d byte %02h first %0b last %0b core %0b",
                               results_seen, want_info.kind, want_info.data,
                               want_info.is_first, want_info.is_last, want_info.core,
                               got_info.kind, got_info.data, got_info.is_first,
                               got_info.is_last, got_info.core));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d info bytes outstanding", cycle_count,
               due_bytes.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    send_idle = 20;
    recv_idle = 30;
    test_device_id_walk();
    test_server_id();
    test_header_rejects();
    test_cut_short();
    test_port_extremes();
    test_position_saturation();
    run_random_traffic(37, 59, rnd16(), 1200);
    run_random_traffic(59, 37, SERVER_PORT_RESET, 1200);
    run_random_traffic(0, 0, 16'h0000, 1200);
    @(negedge clk);
    item_valid = 1'b0;
    while (due_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES * 2) @(posedge clk);
    $display("Sent %0d items in %0d frames and checked %0d extracted bytes, %0d errors.",
             items_sent, frames_sent, results_seen, errors);
    $display("Ports 502, 0, 65535 and random; both sides stalled in turn; one frame saturated the position counter.");
    if (errors == 0 && due_bytes.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
